### design/bnca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnca_pkg
// Shared types and constants for the nearest-center blob association block.
// ----------------------------------------------------------------------------
package bnca_pkg;

    localparam int unsigned MAX_BLOBS = 64;
    localparam int unsigned ADDR_W    = $clog2(MAX_BLOBS);
    localparam int unsigned CNT_W     = ADDR_W + 1;

    localparam int unsigned POS_W  = 16;
    localparam int unsigned ID_W   = 16;
    localparam int unsigned SQ_W   = 2 * POS_W;
    localparam int unsigned DIST_W = SQ_W + 1;

    localparam logic [ID_W-1:0] TRACK_MAX = '1;
    localparam logic [ID_W-1:0] TRACK_RST = ID_W'(1);

    typedef enum logic [1:0] {
        OP_LOAD      = 2'd0,
        OP_MATCH     = 2'd1,
        OP_RELABEL   = 2'd2,
        OP_NEW_FRAME = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_SAT  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_M_RD,
        S_M_DIFF,
        S_M_SQX,
        S_M_SQY,
        S_M_CMP,
        S_P_RD,
        S_P_CHK,
        S_P_APP,
        S_R_RD,
        S_R_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [ID_W-1:0]  id;
    } t_prev_entry;

    typedef struct packed {
        logic [ID_W-1:0]   prev_id;
        logic [ID_W-1:0]   cur_id;
        logic [DIST_W-1:0] sq_dist;
    } t_pair_entry;

    typedef struct packed {
        logic cap_diff;
        logic sq_x;
        logic sq_y;
    } t_dist_ctl;

endpackage

### design/blob_nearest_center_association_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blob_nearest_center_association_top
// Frame-to-frame blob tracker: load previous centers, match current blobs to
// the nearest one, relabel current blobs with a stable track id.
// ----------------------------------------------------------------------------
// One item at a time. Match reads each stored previous center in turn
// (RAM read, difference, x square, y square, compare through the one
// shared squarer), then scans the pair entries for the matched id;
// relabel scans the pair entries for the current blob id. o_ready is
// high only while idle; a finished result waits in the output register,
// so the next beat can be taken before it drains.
// Writing i_cfg_wr_data presets the track counter.
// ----------------------------------------------------------------------------
module blob_nearest_center_association_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_pos_x,
    input  logic [15:0] i_pos_y,
    input  logic [15:0] i_blob_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [15:0] o_track_id,
    output logic [32:0] o_dist_sq,
    output logic [1:0]  o_status
);

    localparam int unsigned AW  = bnca_pkg::ADDR_W;
    localparam int unsigned CW  = bnca_pkg::CNT_W;
    localparam int unsigned DW  = bnca_pkg::DIST_W;
    localparam int unsigned IW  = bnca_pkg::ID_W;
    localparam int unsigned PW  = bnca_pkg::POS_W;
    localparam logic [CW-1:0] CNT_MAX = CW'(bnca_pkg::MAX_BLOBS);

    bnca_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_prev_count, n_prev_count;
    logic [CW-1:0]     r_pair_count, n_pair_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [IW-1:0]     r_next_track, n_next_track;
    logic              r_have, n_have;
    logic              r_o_valid, n_o_valid;

    logic [PW-1:0]     r_pos_x, n_pos_x;
    logic [PW-1:0]     r_pos_y, n_pos_y;
    logic [IW-1:0]     r_blob_id, n_blob_id;
    logic [DW-1:0]     r_best, n_best;
    logic [IW-1:0]     r_best_id, n_best_id;
    logic              r_res_found, n_res_found;
    logic [IW-1:0]     r_res_track, n_res_track;
    logic [DW-1:0]     r_res_dist, n_res_dist;
    bnca_pkg::t_status r_res_status, n_res_status;
    logic              r_o_found, n_o_found;
    logic [IW-1:0]     r_o_track, n_o_track;
    logic [DW-1:0]     r_o_dist, n_o_dist;
    bnca_pkg::t_status r_o_status, n_o_status;

    logic                  prev_we, prev_re;
    logic [AW-1:0]         prev_waddr;
    bnca_pkg::t_prev_entry prev_wdata, prev_rdata;
    logic                  pair_we, pair_re;
    logic [AW-1:0]         pair_waddr;
    bnca_pkg::t_pair_entry pair_wdata, pair_rdata;
    bnca_pkg::t_dist_ctl   dist_ctl;
    logic [DW-1:0]         cand_dist;
    logic [CW-1:0]         idx_inc;

    bnca_ram #(
        .WIDTH ($bits(bnca_pkg::t_prev_entry)),
        .DEPTH (bnca_pkg::MAX_BLOBS)
    ) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prev_we),
        .i_waddr (prev_waddr),
        .i_wdata (prev_wdata),
        .i_re    (prev_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (prev_rdata)
    );

    bnca_ram #(
        .WIDTH ($bits(bnca_pkg::t_pair_entry)),
        .DEPTH (bnca_pkg::MAX_BLOBS)
    ) u_pair_ram (
        .i_clk   (i_clk),
        .i_we    (pair_we),
        .i_waddr (pair_waddr),
        .i_wdata (pair_wdata),
        .i_re    (pair_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (pair_rdata)
    );

    bnca_dist u_dist (
        .i_clk   (i_clk),
        .i_ctl   (dist_ctl),
        .i_cur_x (r_pos_x),
        .i_cur_y (r_pos_y),
        .i_ref_x (prev_rdata.x),
        .i_ref_y (prev_rdata.y),
        .o_dist  (cand_dist)
    );

    assign idx_inc = r_idx + CW'(1);

    always_comb begin
        n_state      = r_state;
        n_prev_count = r_prev_count;
        n_pair_count = r_pair_count;
        n_idx        = r_idx;
        n_next_track = r_next_track;
        n_have       = r_have;
        n_o_valid    = r_o_valid;
        n_pos_x      = r_pos_x;
        n_pos_y      = r_pos_y;
        n_blob_id    = r_blob_id;
        n_best       = r_best;
        n_best_id    = r_best_id;
        n_res_found  = r_res_found;
        n_res_track  = r_res_track;
        n_res_dist   = r_res_dist;
        n_res_status = r_res_status;
        n_o_found    = r_o_found;
        n_o_track    = r_o_track;
        n_o_dist     = r_o_dist;
        n_o_status   = r_o_status;

        prev_we    = 1'b0;
        prev_re    = 1'b0;
        prev_waddr = r_prev_count[AW-1:0];
        prev_wdata = '{x: i_pos_x, y: i_pos_y, id: i_blob_id};
        pair_we    = 1'b0;
        pair_re    = 1'b0;
        pair_waddr = r_idx[AW-1:0];
        pair_wdata = '{prev_id: r_best_id, cur_id: r_blob_id, sq_dist: r_best};
        dist_ctl   = '0;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            bnca_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_pos_x      = i_pos_x;
                    n_pos_y      = i_pos_y;
                    n_blob_id    = i_blob_id;
                    n_idx        = '0;
                    n_have       = 1'b0;
                    n_res_found  = 1'b0;
                    n_res_track  = '0;
                    n_res_dist   = '0;
                    n_res_status = bnca_pkg::STATUS_OK;
                    n_state      = bnca_pkg::S_DONE;
                    case (bnca_pkg::t_op'(i_operation))
                        bnca_pkg::OP_LOAD: begin
                            if (r_prev_count < CNT_MAX) begin
                                prev_we      = 1'b1;
                                n_prev_count = r_prev_count + CW'(1);
                            end else begin
                                n_res_status = bnca_pkg::STATUS_FULL;
                            end
                        end
                        bnca_pkg::OP_MATCH: begin
                            if (r_prev_count != '0) begin
                                n_state = bnca_pkg::S_M_RD;
                            end
                        end
                        bnca_pkg::OP_RELABEL: begin
                            if (r_pair_count != '0) begin
                                n_state = bnca_pkg::S_R_RD;
                            end else begin
                                n_res_track = r_next_track;
                                if (r_next_track == bnca_pkg::TRACK_MAX) begin
                                    n_res_status = bnca_pkg::STATUS_SAT;
                                end else begin
                                    n_next_track = r_next_track + IW'(1);
                                end
                            end
                        end
                        default: begin
                            n_prev_count = '0;
                            n_pair_count = '0;
                        end
                    endcase
                end
            end
            bnca_pkg::S_M_RD: begin
                prev_re = 1'b1;
                n_state = bnca_pkg::S_M_DIFF;
            end
            bnca_pkg::S_M_DIFF: begin
                dist_ctl.cap_diff = 1'b1;
                n_state           = bnca_pkg::S_M_SQX;
            end
            bnca_pkg::S_M_SQX: begin
                dist_ctl.sq_x = 1'b1;
                n_state       = bnca_pkg::S_M_SQY;
            end
            bnca_pkg::S_M_SQY: begin
                dist_ctl.sq_y = 1'b1;
                n_state       = bnca_pkg::S_M_CMP;
            end
            bnca_pkg::S_M_CMP: begin
                // first entry wins ties: replace only on strictly smaller
                if (!r_have || (cand_dist < r_best)) begin
                    n_have    = 1'b1;
                    n_best    = cand_dist;
                    n_best_id = prev_rdata.id;
                end
                if (idx_inc < r_prev_count) begin
                    n_idx   = idx_inc;
                    n_state = bnca_pkg::S_M_RD;
                end else begin
                    n_idx       = '0;
                    n_res_found = 1'b1;
                    n_res_track = n_best_id;
                    n_res_dist  = n_best;
                    n_state     = (r_pair_count != '0) ? bnca_pkg::S_P_RD
                                                       : bnca_pkg::S_P_APP;
                end
            end
            bnca_pkg::S_P_RD: begin
                pair_re = 1'b1;
                n_state = bnca_pkg::S_P_CHK;
            end
            bnca_pkg::S_P_CHK: begin
                if (pair_rdata.prev_id == r_best_id) begin
                    if (r_best < pair_rdata.sq_dist) begin
                        pair_we = 1'b1;
                    end
                    n_state = bnca_pkg::S_DONE;
                end else if (idx_inc < r_pair_count) begin
                    n_idx   = idx_inc;
                    n_state = bnca_pkg::S_P_RD;
                end else begin
                    n_state = bnca_pkg::S_P_APP;
                end
            end
            bnca_pkg::S_P_APP: begin
                pair_waddr = r_pair_count[AW-1:0];
                if (r_pair_count < CNT_MAX) begin
                    pair_we      = 1'b1;
                    n_pair_count = r_pair_count + CW'(1);
                end else begin
                    n_res_status = bnca_pkg::STATUS_FULL;
                end
                n_state = bnca_pkg::S_DONE;
            end
            bnca_pkg::S_R_RD: begin
                pair_re = 1'b1;
                n_state = bnca_pkg::S_R_CHK;
            end
            bnca_pkg::S_R_CHK: begin
                if (pair_rdata.cur_id == r_blob_id) begin
                    n_res_found = 1'b1;
                    n_res_track = pair_rdata.prev_id;
                    n_state     = bnca_pkg::S_DONE;
                end else if (idx_inc < r_pair_count) begin
                    n_idx   = idx_inc;
                    n_state = bnca_pkg::S_R_RD;
                end else begin
                    n_res_track = r_next_track;
                    if (r_next_track == bnca_pkg::TRACK_MAX) begin
                        n_res_status = bnca_pkg::STATUS_SAT;
                    end else begin
                        n_next_track = r_next_track + IW'(1);
                    end
                    n_state = bnca_pkg::S_DONE;
                end
            end
            bnca_pkg::S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_found  = r_res_found;
                    n_o_track  = r_res_track;
                    n_o_dist   = r_res_dist;
                    n_o_status = r_res_status;
                    n_state    = bnca_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bnca_pkg::S_IDLE;
            end
        endcase

        if (i_cfg_wr_en) begin
            n_next_track = i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bnca_pkg::S_IDLE;
            r_prev_count <= '0;
            r_pair_count <= '0;
            r_idx        <= '0;
            r_next_track <= bnca_pkg::TRACK_RST;
            r_have       <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prev_count <= n_prev_count;
            r_pair_count <= n_pair_count;
            r_idx        <= n_idx;
            r_next_track <= n_next_track;
            r_have       <= n_have;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos_x      <= n_pos_x;
        r_pos_y      <= n_pos_y;
        r_blob_id    <= n_blob_id;
        r_best       <= n_best;
        r_best_id    <= n_best_id;
        r_res_found  <= n_res_found;
        r_res_track  <= n_res_track;
        r_res_dist   <= n_res_dist;
        r_res_status <= n_res_status;
        r_o_found    <= n_o_found;
        r_o_track    <= n_o_track;
        r_o_dist     <= n_o_dist;
        r_o_status   <= n_o_status;
    end

    assign o_ready    = (r_state == bnca_pkg::S_IDLE);
    assign o_valid    = r_o_valid;
    assign o_found    = r_o_found;
    assign o_track_id = r_o_track;
    assign o_dist_sq  = r_o_dist;
    assign o_status   = r_o_status;

endmodule

### design/bnca_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnca_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bnca_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/bnca_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnca_dist
// Squared distance unit: absolute differences, then one shared squarer used
// for x and then y. The sum of the two squares is presented to the sequencer.
// ----------------------------------------------------------------------------
module bnca_dist (
    input  logic                           i_clk,
    input  bnca_pkg::t_dist_ctl            i_ctl,
    input  logic [bnca_pkg::POS_W-1:0]     i_cur_x,
    input  logic [bnca_pkg::POS_W-1:0]     i_cur_y,
    input  logic [bnca_pkg::POS_W-1:0]     i_ref_x,
    input  logic [bnca_pkg::POS_W-1:0]     i_ref_y,
    output logic [bnca_pkg::DIST_W-1:0]    o_dist
);

    logic [bnca_pkg::POS_W-1:0] r_dx;
    logic [bnca_pkg::POS_W-1:0] r_dy;
    logic [bnca_pkg::SQ_W-1:0]  r_sqx;
    logic [bnca_pkg::SQ_W-1:0]  r_sqy;
    logic [bnca_pkg::POS_W-1:0] dx;
    logic [bnca_pkg::POS_W-1:0] dy;
    logic [bnca_pkg::POS_W-1:0] mul_op;
    logic [bnca_pkg::SQ_W-1:0]  mul_prod;

    assign dx = (i_cur_x >= i_ref_x) ? (i_cur_x - i_ref_x) : (i_ref_x - i_cur_x);
    assign dy = (i_cur_y >= i_ref_y) ? (i_cur_y - i_ref_y) : (i_ref_y - i_cur_y);

    // shared squarer
    assign mul_op   = i_ctl.sq_y ? r_dy : r_dx;
    assign mul_prod = mul_op * mul_op;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap_diff) begin
            r_dx <= dx;
            r_dy <= dy;
        end
        if (i_ctl.sq_x) begin
            r_sqx <= mul_prod;
        end
        if (i_ctl.sq_y) begin
            r_sqy <= mul_prod;
        end
    end

    assign o_dist = {1'b0, r_sqx} + {1'b0, r_sqy};

endmodule

### design/bnca_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnca_checker
// Port-level checks for the blob association block, bound to the top level.
// ----------------------------------------------------------------------------
module bnca_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_found,
    input logic [15:0] o_track_id,
    input logic [32:0] o_dist_sq,
    input logic [1:0]  o_status
);

    // held result beat stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_track_id) && $stable(o_dist_sq)))
        else $error("result beat changed while stalled");

    // one beat at a time: busy right after acceptance
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready held after input beat");

    a_no_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_dist_sq == '0))
        else $error("distance without a match");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == bnca_pkg::STATUS_SAT))
            |-> (!o_found && (o_track_id == bnca_pkg::TRACK_MAX)))
        else $error("saturation status with wrong track id");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_status == bnca_pkg::STATUS_OK) ||
                     (o_status == bnca_pkg::STATUS_FULL) ||
                     (o_status == bnca_pkg::STATUS_SAT)))
        else $error("unused status code");

endmodule

bind blob_nearest_center_association_top bnca_checker u_bnca_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_found    (o_found),
    .o_track_id (o_track_id),
    .o_dist_sq  (o_dist_sq),
    .o_status   (o_status)
);
